// ----- sv/eps_pkg.sv -----
// Shared types and constants of the encoder position servo.
package eps_pkg;

   // Event kinds carried by a request.
   typedef enum logic [1:0] {
      CMD_EDGE  = 2'd0,
      CMD_INDEX = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_TARGET_POSITION = 3'd0,
      CSR_GAIN_P          = 3'd1,
      CSR_GAIN_I          = 3'd2,
      CSR_GAIN_D          = 3'd3,
      CSR_INTEGRAL_LIMIT  = 3'd4,
      CSR_INDEX_OFFSET    = 3'd5,
      CSR_DRIVE_LIMIT     = 3'd6
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int GAIN_W      = 16;
   localparam int LEVEL_W     = 8;
   localparam int OUT_W       = 8;
   localparam int FRAC_BITS   = 8;
   localparam int INTEGRAL_W  = 18;

   // Register values after reset.
   localparam logic [7:0]        TARGET_RESET         = 8'd0;
   localparam logic [GAIN_W-1:0] GAIN_P_RESET         = 16'd2560;
   localparam logic [GAIN_W-1:0] GAIN_I_RESET         = 16'd179;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET         = 16'd0;
   localparam logic [GAIN_W-1:0] INTEGRAL_LIMIT_RESET = 16'd2560;
   localparam logic [7:0]        INDEX_OFFSET_RESET   = 8'd2;
   localparam logic [LEVEL_W-1:0] DRIVE_LIMIT_RESET   = 8'd255;

   // Loop settings seen by the PID datapath.
   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [GAIN_W-1:0]  integral_limit;
      logic [LEVEL_W-1:0] drive_limit;
   } pid_cfg_type;

endpackage

// ----- sv/eps_front.sv -----
// Front end: decodes each request, keeps the encoder count and forms the tick error.
module eps_front import eps_pkg::*; #(
   parameter int COUNTS_PER_TURN = 178,
   localparam int CW      = $clog2(COUNTS_PER_TURN),
   localparam int EW      = CW + 1,
   localparam int ENTRY_W = 1 + CW + EW
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic               req_phase_a,
   input  logic               req_phase_b,
   input  logic [CW-1:0]      target_mod,
   input  logic [CW-1:0]      offset_mod,
   output logic               push_valid,
   input  logic               push_ready,
   output logic [ENTRY_W-1:0] push_data
);

   localparam logic [CW-1:0]        LAST_COUNT = CW'(COUNTS_PER_TURN - 1);
   localparam logic signed [EW-1:0] HALF_S     = EW'(COUNTS_PER_TURN / 2);
   localparam logic signed [EW-1:0] TURN_S     = EW'(COUNTS_PER_TURN);

   logic [CW-1:0]        count_ff, count_in;
   logic                 clockwise_ff, clockwise_in;
   logic                 is_tick;
   logic                 accept;
   logic signed [EW-1:0] diff;
   logic signed [EW-1:0] err;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // Decode the event and work out the count after it.
   always_comb begin
      count_in     = count_ff;
      clockwise_in = clockwise_ff;
      is_tick      = 1'b0;
      unique case (req_cmd)
         CMD_EDGE: begin
            if (req_phase_a != req_phase_b) begin
               clockwise_in = 1'b1;
               count_in     = (count_ff == '0) ? LAST_COUNT : count_ff - 1'b1;
            end else begin
               clockwise_in = 1'b0;
               count_in     = (count_ff == LAST_COUNT) ? '0 : count_ff + 1'b1;
            end
         end
         CMD_INDEX: begin
            count_in = clockwise_ff ? '0 : offset_mod;
         end
         CMD_TICK: begin
            is_tick = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Shortest-path error from the current count to the target.
   always_comb begin
      diff = EW'({1'b0, target_mod}) - EW'({1'b0, count_ff});
      if (diff > HALF_S) begin
         err = diff - TURN_S;
      end else if (diff < -HALF_S) begin
         err = diff + TURN_S;
      end else begin
         err = diff;
      end
   end

   assign push_data = {is_tick, count_in, err};

   // Count and direction update on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clockwise_ff <= 1'b0;
      end else if (accept) begin
         count_ff     <= count_in;
         clockwise_ff <= clockwise_in;
      end
   end

   // The count never leaves one turn.
   assert property (@(posedge clock) disable iff (reset) count_ff <= LAST_COUNT)
      else $error("encoder count out of range");

   // A tick error always takes the short way round.
   assert property (@(posedge clock) disable iff (reset)
      accept && is_tick |-> (err <= HALF_S) && (err >= -HALF_S))
      else $error("tick error exceeds half a turn");

endmodule

// ----- sv/eps_queue.sv -----
// Short request queue between the front end and the PID datapath.
module eps_queue #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             push;
   logic             pop;

   assign push_ready = (fill_ff != FW'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entries_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + FW'(push) - FW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) fill_ff <= FW'(DEPTH))
      else $error("queue fill count overflow");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with empty fill count");

endmodule

// ----- sv/eps_back.sv -----
// Back end: three-stage PID datapath with the response register and held drive.
module eps_back import eps_pkg::*; #(
   parameter int COUNTS_PER_TURN = 178,
   localparam int CW      = $clog2(COUNTS_PER_TURN),
   localparam int EW      = CW + 1,
   localparam int ENTRY_W = 1 + CW + EW
) (
   input  logic               clock,
   input  logic               reset,
   input  pid_cfg_type        cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  logic [ENTRY_W-1:0] pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LEVEL_W-1:0] rsp_drive_level,
   output logic               rsp_drive_reverse,
   output logic [OUT_W-1:0]   rsp_position,
   output logic signed [OUT_W-1:0] rsp_position_error
);

   localparam int GW  = GAIN_W + 1;
   localparam int DEW = EW + 1;
   localparam int PW  = GW + EW;
   localparam int DW  = GW + DEW;
   localparam int IW  = INTEGRAL_W;
   localparam int SW  = DW + 3;
   localparam int MW  = SW - FRAC_BITS;

   logic adv;

   // Head of the queue.
   logic                 head_tick;
   logic [CW-1:0]        head_pos;
   logic signed [EW-1:0] head_err;

   // Stage 1: products.
   logic signed [GW-1:0]  gain_p_s, gain_i_s, gain_d_s;
   logic signed [DEW-1:0] err_diff;
   logic signed [PW-1:0]  p1_in, i1_in;
   logic signed [DW-1:0]  d1_in;
   logic                  v1_ff, tick1_ff;
   logic [CW-1:0]         pos1_ff;
   logic signed [EW-1:0]  err1_ff;
   logic signed [PW-1:0]  p1_ff, i1_ff;
   logic signed [DW-1:0]  d1_ff;
   logic signed [EW-1:0]  prev_err_ff;

   // Stage 2: integral.
   logic signed [SW-1:0]  isum, lim_s, iclamp;
   logic signed [IW-1:0]  integral_in, integral_ff;
   logic                  v2_ff, tick2_ff;
   logic [CW-1:0]         pos2_ff;
   logic signed [EW-1:0]  err2_ff;
   logic signed [PW-1:0]  p2_ff;
   logic signed [IW-1:0]  int2_ff;
   logic signed [DW-1:0]  d2_ff;

   // Stage 3: drive and response.
   logic signed [SW-1:0]  s_sum;
   logic [SW-1:0]         s_mag;
   logic [MW-1:0]         mag_int;
   logic [LEVEL_W-1:0]    level_in;
   logic                  reverse_in;
   logic                  rsp_valid_ff;
   logic [CW-1:0]         pos3_ff;
   logic [LEVEL_W-1:0]    drive_level_ff;
   logic                  drive_reverse_ff;
   logic signed [EW-1:0]  error_hold_ff;

   // The whole pipeline moves when the response register can take a value.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;

   assign head_tick = pop_data[ENTRY_W-1];
   assign head_pos  = pop_data[EW +: CW];
   assign head_err  = pop_data[EW-1:0];

   // Stage 1: the three gain products.
   assign gain_p_s = {1'b0, cfg.gain_p};
   assign gain_i_s = {1'b0, cfg.gain_i};
   assign gain_d_s = {1'b0, cfg.gain_d};
   assign err_diff = DEW'(head_err) - DEW'(prev_err_ff);
   assign p1_in    = PW'(gain_p_s) * PW'(head_err);
   assign i1_in    = PW'(gain_i_s) * PW'(head_err);
   assign d1_in    = DW'(gain_d_s) * DW'(err_diff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         prev_err_ff <= '0;
      end else if (adv) begin
         v1_ff <= pop_valid;
         if (pop_valid && head_tick) begin
            prev_err_ff <= head_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tick1_ff <= head_tick;
         pos1_ff  <= head_pos;
         err1_ff  <= head_err;
         p1_ff    <= p1_in;
         i1_ff    <= i1_in;
         d1_ff    <= d1_in;
      end
   end

   // Stage 2: accumulate and clamp the integral.
   always_comb begin
      isum  = SW'(integral_ff) + SW'(i1_ff);
      lim_s = SW'(cfg.integral_limit);
      if (isum > lim_s) begin
         iclamp = lim_s;
      end else if (isum < -lim_s) begin
         iclamp = -lim_s;
      end else begin
         iclamp = isum;
      end
      integral_in = IW'(iclamp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff       <= 1'b0;
         integral_ff <= '0;
      end else if (adv) begin
         v2_ff <= v1_ff;
         if (v1_ff && tick1_ff) begin
            integral_ff <= integral_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tick2_ff <= tick1_ff;
         pos2_ff  <= pos1_ff;
         err2_ff  <= err1_ff;
         p2_ff    <= p1_ff;
         int2_ff  <= integral_in;
         d2_ff    <= d1_ff;
      end
   end

   // Stage 3: sum, truncate toward zero and clamp to the drive limit.
   always_comb begin
      s_sum   = SW'(p2_ff) + SW'(int2_ff) + SW'(d2_ff);
      s_mag   = s_sum[SW-1] ? -s_sum : s_sum;
      mag_int = s_mag[SW-1:FRAC_BITS];
      if (mag_int > MW'(cfg.drive_limit)) begin
         level_in = cfg.drive_limit;
      end else begin
         level_in = mag_int[LEVEL_W-1:0];
      end
      reverse_in = s_sum[SW-1] && (level_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         drive_level_ff   <= '0;
         drive_reverse_ff <= 1'b0;
         error_hold_ff    <= '0;
      end else if (adv) begin
         rsp_valid_ff <= v2_ff;
         if (v2_ff && tick2_ff) begin
            drive_level_ff   <= level_in;
            drive_reverse_ff <= reverse_in;
            error_hold_ff    <= err2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos3_ff <= pos2_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_level    = drive_level_ff;
   assign rsp_drive_reverse  = drive_reverse_ff;
   assign rsp_position       = OUT_W'(pos3_ff);
   assign rsp_position_error = OUT_W'(error_hold_ff);

   // Reverse is only ever reported with a nonzero drive.
   assert property (@(posedge clock) disable iff (reset)
      drive_reverse_ff |-> drive_level_ff != '0)
      else $error("reverse flagged with zero drive");

   // After a tick leaves stage 2 the integral lies within its clamp.
   assert property (@(posedge clock) disable iff (reset)
      adv && v1_ff && tick1_ff |=>
         (SW'(integral_ff) <= lim_s) && (SW'(integral_ff) >= -lim_s))
      else $error("integral outside its limit");

endmodule

// ----- sv/encoder_position_pid_servo.sv -----
// Top level of the encoder position servo: configuration registers and block wiring.
//
// Usage:
//   Request channel (req_valid/req_ready): one event per request. req_cmd selects
//   an encoder edge (phases on req_phase_a/b), an index pulse or a control tick;
//   the fourth code leaves all state alone.
//   Response channel (rsp_valid/rsp_ready): exactly one response per request, in
//   order: held drive magnitude and direction, position after the event and the
//   error from the last control tick.
//   Configuration: csr_we writes csr_wdata into the register at csr_index in the
//   same edge; target and index offset are reduced to one turn as they are stored.
//   Write only while no request is in flight.
// Timing:
//   An accepted request is stored in the queue, then passes the stage 1, stage 2 and
//   response registers. One request per cycle is sustained while the receiver keeps
//   up; the edge counter updates as each request is accepted and the PID datapath is
//   a three-stage pipeline whose integral register closes its loop within one stage.
// Reset clears the count, integral, held drive and error and loads the register
// defaults. When the receiver stalls, the response register holds and the
// pipeline freezes; the queue keeps taking requests until it is full.
module encoder_position_pid_servo import eps_pkg::*; #(
   parameter int COUNTS_PER_TURN = 178,
   parameter int QUEUE_DEPTH     = 4,
   localparam int CW      = $clog2(COUNTS_PER_TURN),
   localparam int ENTRY_W = 2 * CW + 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_cmd,
   input  logic                   req_phase_a,
   input  logic                   req_phase_b,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [LEVEL_W-1:0]     rsp_drive_level,
   output logic                   rsp_drive_reverse,
   output logic [OUT_W-1:0]       rsp_position,
   output logic signed [OUT_W-1:0] rsp_position_error,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef logic [255:0][CW-1:0] turn_tbl_type;

   // Reduction of an 8-bit register value to one turn, built at elaboration.
   function automatic turn_tbl_type build_turn_tbl();
      turn_tbl_type tbl;
      for (int i = 0; i < 256; i++) begin
         tbl[i] = CW'(i % COUNTS_PER_TURN);
      end
      return tbl;
   endfunction

   localparam turn_tbl_type TURN_TBL = build_turn_tbl();

   logic [CW-1:0]        target_mod_ff, target_mod_in;
   logic [CW-1:0]        offset_mod_ff, offset_mod_in;
   pid_cfg_type          cfg_ff, cfg_in;
   logic                 push_valid;
   logic                 push_ready;
   logic [ENTRY_W-1:0]   push_data;
   logic                 pop_valid;
   logic                 pop_ready;
   logic [ENTRY_W-1:0]   pop_data;

   // Register write decode.
   always_comb begin
      cfg_in        = cfg_ff;
      target_mod_in = target_mod_ff;
      offset_mod_in = offset_mod_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_POSITION: target_mod_in      = TURN_TBL[csr_wdata[7:0]];
            CSR_GAIN_P:          cfg_in.gain_p      = csr_wdata;
            CSR_GAIN_I:          cfg_in.gain_i      = csr_wdata;
            CSR_GAIN_D:          cfg_in.gain_d      = csr_wdata;
            CSR_INTEGRAL_LIMIT:  cfg_in.integral_limit = csr_wdata;
            CSR_INDEX_OFFSET:    offset_mod_in      = TURN_TBL[csr_wdata[7:0]];
            CSR_DRIVE_LIMIT:     cfg_in.drive_limit = csr_wdata[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_mod_ff         <= TURN_TBL[TARGET_RESET];
         offset_mod_ff         <= TURN_TBL[INDEX_OFFSET_RESET];
         cfg_ff.gain_p         <= GAIN_P_RESET;
         cfg_ff.gain_i         <= GAIN_I_RESET;
         cfg_ff.gain_d         <= GAIN_D_RESET;
         cfg_ff.integral_limit <= INTEGRAL_LIMIT_RESET;
         cfg_ff.drive_limit    <= DRIVE_LIMIT_RESET;
      end else begin
         target_mod_ff <= target_mod_in;
         offset_mod_ff <= offset_mod_in;
         cfg_ff        <= cfg_in;
      end
   end

   eps_front #(
      .COUNTS_PER_TURN (COUNTS_PER_TURN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_phase_a (req_phase_a),
      .req_phase_b (req_phase_b),
      .target_mod  (target_mod_ff),
      .offset_mod  (offset_mod_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   eps_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   eps_back #(
      .COUNTS_PER_TURN (COUNTS_PER_TURN)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_data           (pop_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_level    (rsp_drive_level),
      .rsp_drive_reverse  (rsp_drive_reverse),
      .rsp_position       (rsp_position),
      .rsp_position_error (rsp_position_error)
   );

endmodule

// ----- tb/servo_response_checker.sv -----
// Response checker for the encoder position servo: predicts every response and compares it.
`timescale 1ns / 1ps

module servo_response_checker import eps_pkg::*; #(
   parameter int COUNTS_PER_TURN = 178
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [1:0]              req_cmd,
   input  logic                    req_phase_a,
   input  logic                    req_phase_b,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [LEVEL_W-1:0]      rsp_drive_level,
   input  logic                    rsp_drive_reverse,
   input  logic [OUT_W-1:0]        rsp_position,
   input  logic signed [OUT_W-1:0] rsp_position_error,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      responses_owed,
   output int                      mismatch_count
);

   // One response as the block reports it.
   typedef struct packed {
      logic [LEVEL_W-1:0]      drive_level;
      logic                    drive_reverse;
      logic [OUT_W-1:0]        position;
      logic signed [OUT_W-1:0] position_error;
   } servo_report_type;

   servo_report_type expected_reports[$];

   // Local copy of the configuration registers.
   logic [7:0]         target_reg;
   logic [GAIN_W-1:0]  kp;
   logic [GAIN_W-1:0]  ki;
   logic [GAIN_W-1:0]  kd;
   logic [GAIN_W-1:0]  integral_cap;
   logic [7:0]         offset_reg;
   logic [LEVEL_W-1:0] drive_cap;

   // Local copy of the servo state.
   logic [7:0]                   wheel_count;
   logic                         turning_cw;
   logic signed [INTEGRAL_W-1:0] integ;
   logic signed [7:0]            prev_tick_error;
   logic signed [8:0]            drive_held;
   logic signed [7:0]            error_held;

   int failures;

   // One control tick: shortest-path error, clamped integral, then the clamped drive.
   function automatic void run_pid();
      int     err;
      longint acc;
      longint sum;
      longint mag;
      longint lim;
      err = int'(target_reg % COUNTS_PER_TURN) - int'(wheel_count);
      if (err > COUNTS_PER_TURN / 2) begin
         err -= COUNTS_PER_TURN;
      end else if (err < -(COUNTS_PER_TURN / 2)) begin
         err += COUNTS_PER_TURN;
      end
      lim = longint'(integral_cap);
      acc = longint'(integ) + longint'(ki) * err;
      if (acc > lim) begin
         acc = lim;
      end else if (acc < -lim) begin
         acc = -lim;
      end
      integ = acc[INTEGRAL_W-1:0];
      sum = longint'(kp) * err + acc + longint'(kd) * (err - int'(prev_tick_error));
      // Truncation toward zero: shift the magnitude, then restore the sign.
      mag = ((sum < 0) ? -sum : sum) >>> FRAC_BITS;
      if (mag > longint'(drive_cap)) begin
         mag = longint'(drive_cap);
      end
      drive_held = 9'((sum < 0) ? -mag : mag);
      prev_tick_error = 8'(err);
      error_held = 8'(err);
   endfunction

   // Applies one request to the state and returns the response it must produce.
   function automatic servo_report_type step_servo(logic [1:0] cmd, logic a, logic b);
      servo_report_type rep;
      case (cmd_type'(cmd))
         CMD_EDGE: begin
            if (a != b) begin
               turning_cw = 1'b1;
               wheel_count = (wheel_count == 0) ? 8'(COUNTS_PER_TURN - 1) : wheel_count - 8'd1;
            end else begin
               turning_cw = 1'b0;
               wheel_count = (int'(wheel_count) + 1 >= COUNTS_PER_TURN) ? 8'd0
                                                                       : wheel_count + 8'd1;
            end
         end
         CMD_INDEX: begin
            wheel_count = turning_cw ? 8'd0 : 8'(offset_reg % COUNTS_PER_TURN);
         end
         CMD_TICK: begin
            run_pid();
         end
         default: begin
         end
      endcase
      rep.drive_reverse  = (drive_held < 0);
      rep.drive_level    = (drive_held < 0) ? 8'(-drive_held) : 8'(drive_held);
      rep.position       = wheel_count;
      rep.position_error = error_held;
      return rep;
   endfunction

   // Track register writes, predict on each request and check each response.
   always @(posedge clock) begin
      servo_report_type want;
      servo_report_type got;
      if (reset) begin
         target_reg      = TARGET_RESET;
         kp              = GAIN_P_RESET;
         ki              = GAIN_I_RESET;
         kd              = GAIN_D_RESET;
         integral_cap    = INTEGRAL_LIMIT_RESET;
         offset_reg      = INDEX_OFFSET_RESET;
         drive_cap       = DRIVE_LIMIT_RESET;
         wheel_count     = '0;
         turning_cw      = 1'b0;
         integ           = '0;
         prev_tick_error = '0;
         drive_held      = '0;
         error_held      = '0;
         failures        = 0;
         expected_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_TARGET_POSITION: target_reg   = csr_wdata[7:0];
               CSR_GAIN_P:          kp           = csr_wdata[GAIN_W-1:0];
               CSR_GAIN_I:          ki           = csr_wdata[GAIN_W-1:0];
               CSR_GAIN_D:          kd           = csr_wdata[GAIN_W-1:0];
               CSR_INTEGRAL_LIMIT:  integral_cap = csr_wdata[GAIN_W-1:0];
               CSR_INDEX_OFFSET:    offset_reg   = csr_wdata[7:0];
               CSR_DRIVE_LIMIT:     drive_cap    = csr_wdata[LEVEL_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            expected_reports.push_back(step_servo(req_cmd, req_phase_a, req_phase_b));
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_drive_level, rsp_drive_reverse, rsp_position, rsp_position_error};
            if (expected_reports.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $write("%0t: response with no request waiting: level %0d reverse %0b",
                         $realtime, got.drive_level, got.drive_reverse);
                  $display(" position %0d error %0d", got.position, got.position_error);
               end
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10) begin
                     $write("%0t: response mismatch: expected level %0d reverse %0b",
                            $realtime, want.drive_level, want.drive_reverse);
                     $write(" position %0d error %0d", want.position, want.position_error);
                     $display("; got level %0d reverse %0b position %0d error %0d",
                              got.drive_level, got.drive_reverse, got.position,
                              got.position_error);
                  end
               end
            end
         end
      end
      responses_owed <= expected_reports.size();
      mismatch_count <= failures;
   end

endmodule

// ----- tb/tb_top.sv -----
// Top of the encoder position servo testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import eps_pkg::*;

   localparam int COUNTS_PER_TURN = 178;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_cmd = '0;
   logic                    req_phase_a = 1'b0;
   logic                    req_phase_b = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]      rsp_drive_level;
   logic                    rsp_drive_reverse;
   logic [OUT_W-1:0]        rsp_position;
   logic signed [OUT_W-1:0] rsp_position_error;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    steady = 1'b0;
   int                      responses_owed;
   int                      mismatch_count;

   encoder_position_pid_servo #(
      .COUNTS_PER_TURN(COUNTS_PER_TURN)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_phase_a        (req_phase_a),
      .req_phase_b        (req_phase_b),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_level    (rsp_drive_level),
      .rsp_drive_reverse  (rsp_drive_reverse),
      .rsp_position       (rsp_position),
      .rsp_position_error (rsp_position_error),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   servo_response_checker #(
      .COUNTS_PER_TURN(COUNTS_PER_TURN)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_phase_a        (req_phase_a),
      .req_phase_b        (req_phase_b),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_level    (rsp_drive_level),
      .rsp_drive_reverse  (rsp_drive_reverse),
      .rsp_position       (rsp_position),
      .rsp_position_error (rsp_position_error),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .responses_owed     (responses_owed),
      .mismatch_count     (mismatch_count)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver stalls at random unless a steady stretch is running.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 37);
   end

   // Hard stop in case the handshakes never complete.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Presents one request, after an optional random gap, and waits for its acceptance.
   task automatic send_request(input logic [1:0] cmd, input logic a, input logic b);
      while (!steady && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_phase_a <= a;
      req_phase_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // An encoder edge in the given direction with random phase levels.
   task automatic drive_edge(input logic clockwise);
      logic a;
      a = 1'($urandom_range(0, 1));
      send_request(CMD_EDGE, a, clockwise ? ~a : a);
   endtask

   // Stops sending and waits until every request has been answered.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (responses_owed != 0) @(posedge clock);
   endtask

   // One register write; the caller lowers the write enable after the last one.
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Writes the whole register set; only called while the block is idle.
   task automatic program_servo(input logic [7:0] target, input logic [15:0] p_gain,
                                input logic [15:0] i_gain, input logic [15:0] d_gain,
                                input logic [15:0] i_cap, input logic [7:0] offset,
                                input logic [7:0] d_cap);
      write_register(CSR_TARGET_POSITION, {8'd0, target});
      write_register(CSR_GAIN_P, p_gain);
      write_register(CSR_GAIN_I, i_gain);
      write_register(CSR_GAIN_D, d_gain);
      write_register(CSR_INTEGRAL_LIMIT, i_cap);
      write_register(CSR_INDEX_OFFSET, {8'd0, offset});
      write_register(CSR_DRIVE_LIMIT, {8'd0, d_cap});
      csr_we <= 1'b0;
   endtask

   // Positions mostly within one turn, sometimes beyond it.
   function automatic logic [7:0] pick_position();
      if ($urandom_range(0, 5) == 0) begin
         return 8'($urandom_range(COUNTS_PER_TURN, 255));
      end
      return 8'($urandom_range(0, COUNTS_PER_TURN - 1));
   endfunction

   // Gains spread over full scale, moderate values and the extremes.
   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 65535));
         1:       return 16'($urandom_range(0, 4095));
         2:       return 16'($urandom_range(0, 511));
         default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   // One random event; cw_share sets how often edges turn clockwise.
   task automatic random_item(input int cw_share);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
         drive_edge($urandom_range(0, 99) < cw_share);
      end else if (pick < 54) begin
         send_request(CMD_INDEX, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
         send_request(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
         send_request(CMD_UNUSED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Stimulus: reset, directed cases, then random phases with fresh settings.
   initial begin
      int phase;
      int n;
      int cw_share;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: both directions, a clockwise wrap, index in each direction.
      send_request(CMD_TICK, 1'b0, 1'b0);
      send_request(CMD_EDGE, 1'b0, 1'b0);
      send_request(CMD_EDGE, 1'b1, 1'b1);
      send_request(CMD_TICK, 1'b1, 1'b0);
      send_request(CMD_EDGE, 1'b1, 1'b0);
      send_request(CMD_EDGE, 1'b0, 1'b1);
      send_request(CMD_EDGE, 1'b0, 1'b1);
      send_request(CMD_TICK, 1'b0, 1'b1);
      send_request(CMD_INDEX, 1'b0, 1'b0);
      send_request(CMD_EDGE, 1'b0, 1'b0);
      send_request(CMD_INDEX, 1'b1, 1'b1);
      send_request(CMD_UNUSED, 1'b1, 1'b1);

      // Full-scale settings with target and offset beyond one turn.
      settle();
      program_servo(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
      send_request(CMD_INDEX, 1'b0, 1'b0);
      send_request(CMD_TICK, 1'b0, 1'b0);
      send_request(CMD_EDGE, 1'b1, 1'b0);
      send_request(CMD_TICK, 1'b0, 1'b0);
      send_request(CMD_TICK, 1'b1, 1'b1);

      // Largest positive error, then the first target that wraps to negative.
      settle();
      program_servo(8'd89, 16'd256, 16'd256, 16'd0, 16'hFFFF, 8'd0, 8'd100);
      send_request(CMD_INDEX, 1'b1, 1'b0);
      send_request(CMD_TICK, 1'b0, 1'b0);
      settle();
      program_servo(8'd90, 16'd256, 16'd256, 16'd0, 16'hFFFF, 8'd0, 8'd100);
      send_request(CMD_TICK, 1'b0, 1'b0);

      // Largest negative error, reached through the index offset.
      settle();
      program_servo(8'd0, 16'd256, 16'd256, 16'd512, 16'd1000, 8'd89, 8'd200);
      send_request(CMD_EDGE, 1'b1, 1'b1);
      send_request(CMD_INDEX, 1'b0, 1'b0);
      send_request(CMD_TICK, 1'b0, 1'b0);
      send_request(CMD_UNUSED, 1'b0, 1'b0);

      // Random phases: all zero, all maximum, then random settings.
      cw_share = 50;
      for (phase = 0; phase < 8; phase++) begin
         settle();
         case (phase)
            0: program_servo(8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
            1: program_servo(8'd177, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd177, 8'd255);
            default: program_servo(pick_position(), pick_gain(), pick_gain(), pick_gain(),
                                   pick_gain(), pick_position(), 8'($urandom_range(0, 255)));
         endcase
         steady <= (phase == 3);
         for (n = 0; n < 230; n++) begin
            if (n % 50 == 0) begin
               cw_share = $urandom_range(5, 95);
            end
            random_item(cw_share);
         end
      end

      // Drain and give late responses a chance to show up.
      settle();
      steady <= 1'b0;
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
